// ===== src/mma_pkg.sv =====
// Shared types and codes for the matrix multiply-accumulate block.
// Holds the operation codes, register indexes, beat structs and pipeline tag.
// No dependencies; every other file imports this package.
package mma_pkg;

  // Operation codes carried in the input beat.
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_MULT    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  // Dimension registers come out of reset at the full matrix size.
  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 4'd8;

  // One input beat.
  typedef struct packed {
    op_e                operation;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] element_value;
  } in_item_t;

  // One result beat: a C entry in Q32.32.
  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [63:0] out_value;
    logic               last_entry;
  } out_item_t;

  // Tag that travels with each multiply step through the pipeline.
  typedef struct packed {
    logic       vld;    // step is live
    logic       first;  // first inner step of an entry: seed from C
    logic       last;   // final inner step of an entry: write C, emit
    logic       done;   // final step of the whole run
    logic [2:0] row;
    logic [2:0] col;
  } mac_tag_t;

endpackage

// ===== src/mma_mac.sv =====
// Shared multiply and saturating accumulate unit for the matrix block.
// Registers the 32x32 product, then adds it into a running Q32.32 sum.
// Depends on mma_pkg for the step tag.
module mma_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  logic signed [63:0]  seed_i,
  input  mma_pkg::mac_tag_t   tag_i,
  output logic signed [63:0]  sum_o,
  output mma_pkg::mac_tag_t   tag_o
);
  import mma_pkg::*;

  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

  logic signed [63:0] prod_d, prod_q;
  logic signed [63:0] seed_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] base;
  logic signed [63:0] raw_sum;
  mac_tag_t           tag_q;

  // Full-precision product of two Q16.16 values is exact in Q32.32.
  assign prod_d = a_i * b_i;

  // Product stage: registers the product, the seed and the tag of the operands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    seed_q <= seed_i;
  end

  // Saturating add: overflow when both addends share a sign the sum lacks.
  always_comb begin
    base    = tag_q.first ? seed_q : acc_q;
    raw_sum = base + prod_q;
    if ((base[63] == prod_q[63]) && (raw_sum[63] != base[63])) begin
      sum_o = base[63] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_o = raw_sum;
    end
  end

  // Running sum for the entry in progress.
  always_ff @(posedge clk_i) begin
    if (tag_q.vld) begin
      acc_q <= sum_o;
    end
  end

  assign tag_o = tag_q;

endmodule

// ===== src/matrix_multiply_accumulate_top.sv =====
// Top level of the matrix multiply-accumulate block (C += A * B).
// Holds the A, B and C stores, the dimension registers and the step sequencer.
// Depends on mma_pkg and mma_mac.
//
//   Channel   Signals                         Handshake
//   -------   -----------------------------   --------------------------------
//   command   start_i, busy_o, in_i           beat taken when start_i & !busy_o
//   result    out_valid_o, out_o              one-cycle strobe, always taken
//   config    cfg_we_i, cfg_idx_i, cfg_data_i write when cfg_we_i is high
//
// Element writes and clears do not raise busy_o and may come back to back.
// A multiply keeps busy_o high while it issues one inner step per cycle
// through the shared multiplier and then drains the read and product
// stages; results leave one per inner-loop completion.
// Reset is asynchronous, active low, and marks every C entry as zero.
// The result side cannot stall; each result beat is shown for one cycle.
module matrix_multiply_accumulate_top #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  mma_pkg::in_item_t                   in_i,
  output logic                                out_valid_o,
  output mma_pkg::out_item_t                  out_o,
  input  logic                                cfg_we_i,
  input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mma_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mma_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [AW-1:0]         STRIDE  = AW'(MAX_DIM);
  localparam logic [CFG_DATA_W-1:0] DIM_MAX = CFG_DATA_W'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] rows_q, inner_q, cols_q;
  logic [CFG_DATA_W-1:0] m_last, n_last, p_last;

  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          i_end, j_end, k_end;

  logic          accept;
  logic          wr_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] a_addr, b_addr;
  logic [AW-1:0] c_rd_addr, c_wr_addr;

  logic signed [31:0] a_mem [DEPTH];
  logic signed [31:0] b_mem [DEPTH];
  logic signed [63:0] c_mem [DEPTH];
  logic [DEPTH-1:0]   c_vld_q;

  logic signed [31:0] a_rd_q, b_rd_q;
  logic signed [63:0] c_rd_q;
  logic               c_hit_q;
  logic signed [63:0] seed;

  mac_tag_t           issue_tag, s1_tag_q, s2_tag;
  logic signed [63:0] sum;

  logic      out_valid_q;
  out_item_t out_q;

  // Effective dimensions: zero acts as one, oversize acts as MAX_DIM.
  function automatic logic [CFG_DATA_W-1:0] dim_last(input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] e;
    if (v == '0) begin
      e = CFG_DATA_W'(1);
    end else if (v > DIM_MAX) begin
      e = DIM_MAX;
    end else begin
      e = v;
    end
    return e - CFG_DATA_W'(1);
  endfunction

  assign m_last = dim_last(rows_q);
  assign n_last = dim_last(inner_q);
  assign p_last = dim_last(cols_q);

  // Dimension registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_DIM_RESET;
      inner_q <= CFG_DIM_RESET;
      cols_q  <= CFG_DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A:    rows_q  <= cfg_data_i;
        CFG_INNER_DIM: inner_q <= cfg_data_i;
        CFG_COLS_B:    cols_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Loop counters: k innermost, then j, then i.
  assign k_end = (CFG_DATA_W'(k_q) == n_last);
  assign j_end = (CFG_DATA_W'(j_q) == p_last);
  assign i_end = (CFG_DATA_W'(i_q) == m_last);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.operation == OP_MULT)) begin
          state_d = ST_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_d = k_q + IW'(1);
        end else begin
          k_d = '0;
          if (!j_end) begin
            j_d = j_q + IW'(1);
          end else begin
            j_d = '0;
            if (!i_end) begin
              i_d = i_q + IW'(1);
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (s2_tag.vld && s2_tag.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Step issue: addresses and tag for the current (i, j, k).
  assign a_addr    = AW'(i_q) * STRIDE + AW'(k_q);
  assign b_addr    = AW'(k_q) * STRIDE + AW'(j_q);
  assign c_rd_addr = AW'(i_q) * STRIDE + AW'(j_q);

  always_comb begin
    issue_tag       = '0;
    issue_tag.vld   = (state_q == ST_RUN);
    issue_tag.first = (k_q == '0);
    issue_tag.last  = k_end;
    issue_tag.done  = k_end && j_end && i_end;
    issue_tag.row   = 3'(i_q);
    issue_tag.col   = 3'(j_q);
  end

  // Element writes into A and B; out-of-range indexes are dropped.
  assign wr_in_range = (32'(in_i.row_index) < MAX_DIM) && (32'(in_i.col_index) < MAX_DIM);
  assign wr_addr     = AW'(in_i.row_index) * STRIDE + AW'(in_i.col_index);

  always_ff @(posedge clk_i) begin
    if (accept && wr_in_range && (in_i.operation == OP_WRITE_A)) begin
      a_mem[wr_addr] <= in_i.element_value;
    end
    a_rd_q <= a_mem[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_in_range && (in_i.operation == OP_WRITE_B)) begin
      b_mem[wr_addr] <= in_i.element_value;
    end
    b_rd_q <= b_mem[b_addr];
  end

  // C store: written at the end of each entry, read when the entry starts.
  assign c_wr_addr = AW'(s2_tag.row) * STRIDE + AW'(s2_tag.col);

  always_ff @(posedge clk_i) begin
    if (s2_tag.vld && s2_tag.last) begin
      c_mem[c_wr_addr] <= sum;
    end
    c_rd_q <= c_mem[c_rd_addr];
  end

  // Valid bits: an entry never written since reset or clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= '0;
      c_hit_q <= 1'b0;
    end else begin
      c_hit_q <= c_vld_q[c_rd_addr];
      if (accept && (in_i.operation == OP_CLEAR)) begin
        c_vld_q <= '0;
      end else if (s2_tag.vld && s2_tag.last) begin
        c_vld_q[c_wr_addr] <= 1'b1;
      end
    end
  end

  assign seed = c_hit_q ? c_rd_q : '0;

  // Read stage tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else begin
      s1_tag_q <= issue_tag;
    end
  end

  mma_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .seed_i (seed),
    .tag_i  (s1_tag_q),
    .sum_o  (sum),
    .tag_o  (s2_tag)
  );

  // Result register: one beat per finished C entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s2_tag.vld && s2_tag.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_tag.vld && s2_tag.last) begin
      out_q.out_row    <= s2_tag.row;
      out_q.out_col    <= s2_tag.col;
      out_q.out_value  <= sum;
      out_q.last_entry <= s2_tag.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
